[src/rsos_pkg.sv]
// Shared types and constants of the range scan object segmenter.
package rsos_pkg;

    localparam int IN_TDATA_W   = 48;
    localparam int OUT_TDATA_W  = 48;
    localparam int SAMPLE_W     = 12;
    localparam int ANGLE_W      = 8;
    localparam int NUM_W        = 5;
    localparam int CFG_ADDR_W   = 3;
    localparam int SUM_W        = 14;
    localparam int SAMPLES_USED = 3;

    // floor(x/3) = (x * 21846) >> 16 for every x below 32768
    localparam logic [14:0] RECIP3 = 15'd21846;
    localparam logic [SAMPLE_W-1:0] DIST_NONE = '1;
    localparam logic [ANGLE_W-1:0]  WIDTH_NONE = '1;

    typedef enum logic [CFG_ADDR_W-1:0] {
        REG_MIN_VALID_DISTANCE = 3'd0,
        REG_MAX_VALID_DISTANCE = 3'd1,
        REG_MIN_VALID_COUNT    = 3'd2,
        REG_OBJECT_THRESHOLD   = 3'd3,
        REG_CHANGE_THRESHOLD   = 3'd4,
        REG_MIN_WIDTH          = 3'd5,
        REG_MAX_WIDTH          = 3'd6,
        REG_ANGLE_STEP         = 3'd7
    } reg_idx_t;

    typedef struct packed {
        logic [SAMPLE_W-1:0] min_valid_distance;
        logic [SAMPLE_W-1:0] max_valid_distance;
        logic [1:0]          min_valid_count;
        logic [SAMPLE_W-1:0] object_threshold;
        logic [SAMPLE_W-1:0] change_threshold;
        logic [ANGLE_W-1:0]  min_width;
        logic [ANGLE_W-1:0]  max_width;
        logic [ANGLE_W-1:0]  angle_step;
    } cfg_t;

    typedef struct packed {
        logic load;
        logic divide;
        logic track;
        logic close;
        logic push_rec;
        logic push_sum;
    } dp_cmd_t;

    typedef struct packed {
        logic rec_valid;
        logic final_step;
        logic out_free;
    } dp_stat_t;

    typedef enum logic [5:0] {
        ST_IDLE  = 6'b000001,
        ST_DIV   = 6'b000010,
        ST_TRACK = 6'b000100,
        ST_CLOSE = 6'b001000,
        ST_REC   = 6'b010000,
        ST_SUM   = 6'b100000
    } state_t;

endpackage

[src/range_scan_object_segmenter_core.sv]
// Top level of the range scan object segmenter.
//
//  port group      dir  tdata (low bit up)                              tuser       tlast
//  s_axis          in   angle, sample x3, pad                           first_step  final_step
//  m_axis          out  obj_id, start_deg, end_deg, nearest,
//                       width_deg, target_number, overflow, pad         kind        last_of_run
//  cfg             in   cfg_we / cfg_addr / cfg_wdata, write only
//
// A step passes through accept, average, track and close, then a result state (REC or
// SUM) for each result word; the averaging divide by three is a single multiply.
// A word is taken while the previous word still waits in the output register.
// rst_n clears the sweep state and loads the register defaults.
// A stalled m_axis holds the sequencer in its result state; s_axis waits meanwhile.
module range_scan_object_segmenter_core #(
    parameter int MAX_OBJECTS = 16
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    input  logic [rsos_pkg::IN_TDATA_W-1:0]  s_axis_tdata,  // angle, sample x3, pad
    input  logic                             s_axis_tuser,  // first_step
    input  logic                             s_axis_tlast,  // final_step
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    output logic [rsos_pkg::OUT_TDATA_W-1:0] m_axis_tdata,  // number, start, end, nearest,
                                                            // width, target, overflow, pad
    output logic                             m_axis_tuser,  // kind
    output logic                             m_axis_tlast,  // last_of_run
    input  logic                             cfg_we,
    input  logic [rsos_pkg::CFG_ADDR_W-1:0]  cfg_addr,
    input  logic [rsos_pkg::SAMPLE_W-1:0]    cfg_wdata
);
    import rsos_pkg::*;

    cfg_t     cfg;
    dp_cmd_t  cmd;
    dp_stat_t stat;

    rsos_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    rsos_ctrl u_ctrl (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .stat          (stat),
        .cmd           (cmd)
    );

    rsos_dp #(
        .MAX_OBJECTS (MAX_OBJECTS)
    ) u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg           (cfg),
        .cmd           (cmd),
        .stat          (stat),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

endmodule

[src/rsos_cfg.sv]
// Configuration register bank.
module rsos_cfg (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [rsos_pkg::CFG_ADDR_W-1:0] cfg_addr,
    input  logic [rsos_pkg::SAMPLE_W-1:0]   cfg_wdata,
    output rsos_pkg::cfg_t                  cfg
);
    import rsos_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            unique case (reg_idx_t'(cfg_addr))
                REG_MIN_VALID_DISTANCE: cfg_next.min_valid_distance = cfg_wdata;
                REG_MAX_VALID_DISTANCE: cfg_next.max_valid_distance = cfg_wdata;
                REG_MIN_VALID_COUNT:    cfg_next.min_valid_count    = cfg_wdata[1:0];
                REG_OBJECT_THRESHOLD:   cfg_next.object_threshold   = cfg_wdata;
                REG_CHANGE_THRESHOLD:   cfg_next.change_threshold   = cfg_wdata;
                REG_MIN_WIDTH:          cfg_next.min_width          = cfg_wdata[ANGLE_W-1:0];
                REG_MAX_WIDTH:          cfg_next.max_width          = cfg_wdata[ANGLE_W-1:0];
                REG_ANGLE_STEP:         cfg_next.angle_step         = cfg_wdata[ANGLE_W-1:0];
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.min_valid_distance <= 12'd20;
            cfg_reg.max_valid_distance <= 12'd1100;
            cfg_reg.min_valid_count    <= 2'd2;
            cfg_reg.object_threshold   <= 12'd1000;
            cfg_reg.change_threshold   <= 12'd20;
            cfg_reg.min_width          <= 8'd4;
            cfg_reg.max_width          <= 8'd60;
            cfg_reg.angle_step         <= 8'd4;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

[src/rsos_ctrl.sv]
// Step sequencer: accept, divide, track, close, then hand out results.
module rsos_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               s_axis_tvalid,
    output logic               s_axis_tready,
    input  rsos_pkg::dp_stat_t stat,
    output rsos_pkg::dp_cmd_t  cmd
);
    import rsos_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_axis_tvalid)
                    state_next = ST_DIV;
            end
            ST_DIV:   state_next = ST_TRACK;
            ST_TRACK: state_next = ST_CLOSE;
            ST_CLOSE:
            begin
                priority if (stat.rec_valid)
                    state_next = ST_REC;
                else if (stat.final_step)
                    state_next = ST_SUM;
                else
                    state_next = ST_IDLE;
            end
            ST_REC:
            begin
                if (stat.out_free)
                    state_next = stat.final_step ? ST_SUM : ST_IDLE;
            end
            ST_SUM:
            begin
                if (stat.out_free)
                    state_next = ST_IDLE;
            end
            default:  state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    assign s_axis_tready = (state_reg == ST_IDLE);

    always_comb
    begin
        cmd.load     = (state_reg == ST_IDLE) && s_axis_tvalid;
        cmd.divide   = (state_reg == ST_DIV);
        cmd.track    = (state_reg == ST_TRACK);
        cmd.close    = (state_reg == ST_CLOSE);
        cmd.push_rec = (state_reg == ST_REC) && stat.out_free;
        cmd.push_sum = (state_reg == ST_SUM) && stat.out_free;
    end

endmodule

[src/rsos_dp.sv]
// Datapath: sample filter, averaging, run tracking, object records, output word.
module rsos_dp #(
    parameter int MAX_OBJECTS = 16
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  rsos_pkg::cfg_t                   cfg,
    input  rsos_pkg::dp_cmd_t                cmd,
    output rsos_pkg::dp_stat_t               stat,
    input  logic [rsos_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
    input  logic                             s_axis_tuser,
    input  logic                             s_axis_tlast,
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    output logic [rsos_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
    output logic                             m_axis_tuser,
    output logic                             m_axis_tlast
);
    import rsos_pkg::*;

    localparam int CNT_W = $clog2(MAX_OBJECTS + 1);
    localparam logic [CNT_W-1:0] CAPACITY = CNT_W'(MAX_OBJECTS);

    // step registers
    logic [ANGLE_W-1:0]  angle_reg, angle_next;
    logic                final_reg, final_next;
    logic [SUM_W-1:0]    sum_reg, sum_next;
    logic [1:0]          cnt_reg, cnt_next;
    logic [SAMPLE_W-1:0] dist_reg, dist_next;
    logic                usable_reg, usable_next;
    logic                far_pend_reg, far_pend_next;
    logic                fin_pend_reg, fin_pend_next;

    // sweep state
    logic                inside_reg, inside_next;
    logic [ANGLE_W-1:0]  run_start_reg, run_start_next;
    logic [SAMPLE_W-1:0] run_nearest_reg, run_nearest_next;
    logic [SAMPLE_W-1:0] prev_dist_reg, prev_dist_next;
    logic [CNT_W-1:0]    found_reg, found_next;
    logic [ANGLE_W-1:0]  narrow_w_reg, narrow_w_next;
    logic [CNT_W-1:0]    narrow_num_reg, narrow_num_next;
    logic                dropped_reg, dropped_next;

    // pending object record
    logic [CNT_W-1:0]    rec_num_reg, rec_num_next;
    logic [ANGLE_W-1:0]  rec_start_reg, rec_start_next;
    logic [ANGLE_W-1:0]  rec_end_reg, rec_end_next;
    logic [SAMPLE_W-1:0] rec_near_reg, rec_near_next;
    logic [ANGLE_W-1:0]  rec_w_reg, rec_w_next;

    // output word
    logic                   out_valid_reg, out_valid_next;
    logic [OUT_TDATA_W-1:0] out_data_reg, out_data_next;
    logic                   out_kind_reg, out_kind_next;
    logic                   out_last_reg, out_last_next;

    logic [SAMPLE_W-1:0] smp [SAMPLES_USED];
    logic [SUM_W-1:0]    in_sum;
    logic [1:0]          in_cnt;
    logic [1:0]          need;
    logic [28:0]         prod3;
    logic [SAMPLE_W-1:0] quot;
    logic                close_now;
    logic [SAMPLE_W-1:0] delta;
    logic [SAMPLE_W-1:0] near_min;
    logic                do_close;
    logic [ANGLE_W-1:0]  end_deg;
    logic [ANGLE_W:0]    diff9;
    logic [ANGLE_W-1:0]  run_w;
    logic                width_ok;
    logic                room;
    logic                rec_hit;
    logic [CNT_W-1:0]    found_inc;
    logic                out_free;
    logic [CNT_W+NUM_W-1:0] rec_num_ext;
    logic [CNT_W+NUM_W-1:0] tgt_ext;
    logic [OUT_TDATA_W-1:0] rec_word;
    logic [OUT_TDATA_W-1:0] sum_word;

    assign smp[0] = s_axis_tdata[19:8];
    assign smp[1] = s_axis_tdata[31:20];
    assign smp[2] = s_axis_tdata[43:32];

    always_comb
    begin
        in_sum = '0;
        in_cnt = '0;
        for (int i = 0; i < SAMPLES_USED; i++)
        begin
            if (smp[i] >= cfg.min_valid_distance && smp[i] <= cfg.max_valid_distance)
            begin
                in_sum = in_sum + SUM_W'(smp[i]);
                in_cnt = in_cnt + 2'd1;
            end
        end
    end

    assign need  = (cfg.min_valid_count == 2'd0) ? 2'd1 : cfg.min_valid_count;
    assign prod3 = sum_reg * RECIP3;

    always_comb
    begin
        unique case (cnt_reg)
            2'd1:    quot = sum_reg[SAMPLE_W-1:0];
            2'd2:    quot = sum_reg[SAMPLE_W:1];
            2'd3:    quot = prod3[27:16];
            default: quot = DIST_NONE;
        endcase
    end

    assign close_now = usable_reg && (dist_reg < cfg.object_threshold);
    assign delta     = (dist_reg > prev_dist_reg) ? dist_reg - prev_dist_reg
                                                  : prev_dist_reg - dist_reg;
    assign near_min  = (dist_reg < run_nearest_reg) ? dist_reg : run_nearest_reg;

    // run closing
    assign do_close  = far_pend_reg || fin_pend_reg;
    assign end_deg   = !far_pend_reg ? angle_reg :
                       (angle_reg >= cfg.angle_step) ? angle_reg - cfg.angle_step : '0;
    assign diff9     = {1'b0, angle_reg} - {1'b0, run_start_reg};
    assign run_w     = diff9[ANGLE_W-1:0];
    assign width_ok  = !diff9[ANGLE_W] && (run_w >= cfg.min_width) && (run_w <= cfg.max_width);
    assign room      = found_reg < CAPACITY;
    assign rec_hit   = do_close && width_ok && room;
    assign found_inc = found_reg + 1'b1;

    assign out_free  = !out_valid_reg || m_axis_tready;

    assign rec_num_ext = {{NUM_W{1'b0}}, rec_num_reg};
    assign tgt_ext     = {{NUM_W{1'b0}}, narrow_num_reg};

    assign rec_word = {1'b0, dropped_reg, {NUM_W{1'b0}}, rec_w_reg, rec_near_reg,
                       rec_end_reg, rec_start_reg, rec_num_ext[NUM_W-1:0]};
    assign sum_word = {1'b0, dropped_reg, tgt_ext[NUM_W-1:0], {ANGLE_W{1'b0}},
                       {SAMPLE_W{1'b0}}, {ANGLE_W{1'b0}}, {ANGLE_W{1'b0}}, {NUM_W{1'b0}}};

    always_comb
    begin
        angle_next       = angle_reg;
        final_next       = final_reg;
        sum_next         = sum_reg;
        cnt_next         = cnt_reg;
        dist_next        = dist_reg;
        usable_next      = usable_reg;
        far_pend_next    = far_pend_reg;
        fin_pend_next    = fin_pend_reg;
        inside_next      = inside_reg;
        run_start_next   = run_start_reg;
        run_nearest_next = run_nearest_reg;
        prev_dist_next   = prev_dist_reg;
        found_next       = found_reg;
        narrow_w_next    = narrow_w_reg;
        narrow_num_next  = narrow_num_reg;
        dropped_next     = dropped_reg;
        rec_num_next     = rec_num_reg;
        rec_start_next   = rec_start_reg;
        rec_end_next     = rec_end_reg;
        rec_near_next    = rec_near_reg;
        rec_w_next       = rec_w_reg;

        priority if (cmd.load)
        begin
            angle_next = s_axis_tdata[ANGLE_W-1:0];
            final_next = s_axis_tlast;
            sum_next   = in_sum;
            cnt_next   = in_cnt;
            if (s_axis_tuser)
            begin
                inside_next      = 1'b0;
                run_start_next   = '0;
                run_nearest_next = DIST_NONE;
                prev_dist_next   = DIST_NONE;
                found_next       = '0;
                narrow_w_next    = WIDTH_NONE;
                narrow_num_next  = '0;
                dropped_next     = 1'b0;
            end
        end
        else if (cmd.divide)
        begin
            usable_next = (cnt_reg >= need) && (cnt_reg != 2'd0);
            dist_next   = ((cnt_reg >= need) && (cnt_reg != 2'd0)) ? quot : DIST_NONE;
        end
        else if (cmd.track)
        begin
            far_pend_next  = !close_now && inside_reg;
            fin_pend_next  = close_now && final_reg;
            prev_dist_next = dist_reg;
            if (close_now)
            begin
                if (!inside_reg)
                begin
                    inside_next      = 1'b1;
                    run_start_next   = angle_reg;
                    run_nearest_next = near_min;
                end
                else if (delta <= cfg.change_threshold)
                begin
                    run_nearest_next = near_min;
                end
            end
        end
        else if (cmd.close)
        begin
            if (do_close || final_reg)
            begin
                inside_next      = 1'b0;
                run_nearest_next = DIST_NONE;
            end
            if (do_close && width_ok)
            begin
                if (room)
                begin
                    found_next = found_inc;
                    if (narrow_num_reg == '0 || run_w < narrow_w_reg)
                    begin
                        narrow_w_next   = run_w;
                        narrow_num_next = found_inc;
                    end
                    rec_num_next   = found_inc;
                    rec_start_next = run_start_reg;
                    rec_end_next   = end_deg;
                    rec_near_next  = run_nearest_reg;
                    rec_w_next     = run_w;
                end
                else
                begin
                    dropped_next = 1'b1;
                end
            end
        end
        else
        begin
            angle_next = angle_reg;
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        out_kind_next  = out_kind_reg;
        out_last_next  = out_last_reg;
        priority if (cmd.push_rec)
        begin
            out_valid_next = 1'b1;
            out_data_next  = rec_word;
            out_kind_next  = 1'b0;
            out_last_next  = !final_reg;
        end
        else if (cmd.push_sum)
        begin
            out_valid_next = 1'b1;
            out_data_next  = sum_word;
            out_kind_next  = 1'b1;
            out_last_next  = 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            final_reg       <= 1'b0;
            far_pend_reg    <= 1'b0;
            fin_pend_reg    <= 1'b0;
            usable_reg      <= 1'b0;
            inside_reg      <= 1'b0;
            run_start_reg   <= '0;
            run_nearest_reg <= DIST_NONE;
            prev_dist_reg   <= DIST_NONE;
            found_reg       <= '0;
            narrow_w_reg    <= WIDTH_NONE;
            narrow_num_reg  <= '0;
            dropped_reg     <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            final_reg       <= final_next;
            far_pend_reg    <= far_pend_next;
            fin_pend_reg    <= fin_pend_next;
            usable_reg      <= usable_next;
            inside_reg      <= inside_next;
            run_start_reg   <= run_start_next;
            run_nearest_reg <= run_nearest_next;
            prev_dist_reg   <= prev_dist_next;
            found_reg       <= found_next;
            narrow_w_reg    <= narrow_w_next;
            narrow_num_reg  <= narrow_num_next;
            dropped_reg     <= dropped_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        angle_reg     <= angle_next;
        sum_reg       <= sum_next;
        cnt_reg       <= cnt_next;
        dist_reg      <= dist_next;
        rec_num_reg   <= rec_num_next;
        rec_start_reg <= rec_start_next;
        rec_end_reg   <= rec_end_next;
        rec_near_reg  <= rec_near_next;
        rec_w_reg     <= rec_w_next;
        out_data_reg  <= out_data_next;
        out_kind_reg  <= out_kind_next;
        out_last_reg  <= out_last_next;
    end

    assign stat.rec_valid  = rec_hit;
    assign stat.final_step = final_reg;
    assign stat.out_free   = out_free;

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;
    assign m_axis_tuser  = out_kind_reg;
    assign m_axis_tlast  = out_last_reg;

`ifndef SYNTH
    a_found_cap: assert property (@(posedge clk) disable iff (!rst_n)
        found_reg <= CAPACITY)
        else $error("object count beyond capacity");

    a_narrow_seen: assert property (@(posedge clk) disable iff (!rst_n)
        narrow_num_reg <= found_reg)
        else $error("narrowest object number beyond objects found");

    a_drop_full: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(dropped_reg) |-> (found_reg == CAPACITY))
        else $error("object dropped while capacity left");

    a_final_shut: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.close && final_reg) |=> !inside_reg)
        else $error("run still open after final step");
`endif

endmodule

[sim/tb.sv]
// Testbench for range_scan_object_segmenter_core: directed and random sweeps checked word by word.
module tb;
    import rsos_pkg::*;

    localparam int OBJ_CAPACITY = 16;
    localparam int SETTLE_CYCLES = 12;

    typedef struct {
        bit        kind;
        bit [4:0]  obj_num;
        bit [7:0]  start_deg;
        bit [7:0]  end_deg;
        bit [11:0] nearest;
        bit [7:0]  width_deg;
        bit [4:0]  target_num;
        bit        overflow;
        bit        last_word;
    } seg_word_t;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;
    logic                   s_axis_tuser = 1'b0;
    logic                   s_axis_tlast = 1'b0;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;
    logic                   m_axis_tuser;
    logic                   m_axis_tlast;
    logic                   cfg_we = 1'b0;
    logic [CFG_ADDR_W-1:0]  cfg_addr = '0;
    logic [SAMPLE_W-1:0]    cfg_wdata = '0;

    int mismatch_count = 0;
    int tx_gap_pct = 0;
    int rx_stall_pct = 0;
    int rx_hold_req = 0;

    // segmenter state as predicted
    cfg_t        model_cfg;
    bit          in_run;
    logic [7:0]  run_from;
    int          run_min;
    int          last_dist;
    int          objects_out;
    int          narrow_w;
    int          narrow_id;
    bit          dropped;

    seg_word_t step_words[$];
    seg_word_t expected_words[$];

    range_scan_object_segmenter_core #(
        .MAX_OBJECTS(OBJ_CAPACITY)
    ) uut (
        .clk(clk),
        .rst_n(rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .s_axis_tuser(s_axis_tuser),
        .s_axis_tlast(s_axis_tlast),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata),
        .m_axis_tuser(m_axis_tuser),
        .m_axis_tlast(m_axis_tlast),
        .cfg_we(cfg_we),
        .cfg_addr(cfg_addr),
        .cfg_wdata(cfg_wdata)
    );

    always #5 clk = ~clk;

    task automatic report_error(input string msg);
        $display("%0t: %s", $time, msg);
        mismatch_count++;
    endtask

    task automatic check_field(input string name, input int got_v, input int want_v);
        if (got_v != want_v)
            report_error($sformatf("%s got %0d expected %0d", name, got_v, want_v));
    endtask

    task automatic clear_sweep();
        in_run = 1'b0;
        run_from = '0;
        run_min = 4095;
        last_dist = 4095;
        objects_out = 0;
        narrow_w = 255;
        narrow_id = 0;
        dropped = 1'b0;
    endtask

    task automatic close_object(input logic [7:0] ang, input logic [7:0] end_ang);
        int w;
        int lo;
        int hi;
        w = int'(ang) - int'(run_from);
        lo = model_cfg.min_width;
        hi = model_cfg.max_width;
        if (w >= 0 && w >= lo && w <= hi)
        begin
            if (objects_out < OBJ_CAPACITY)
            begin
                objects_out++;
                if (narrow_id == 0 || w < narrow_w)
                begin
                    narrow_w = w;
                    narrow_id = objects_out;
                end
                step_words.push_back('{1'b0, 5'(objects_out), run_from, end_ang,
                                       12'(run_min), 8'(w), 5'd0, 1'b0, 1'b0});
            end
            else
                dropped = 1'b1;
        end
        in_run = 1'b0;
        run_min = 4095;
    endtask

    task automatic predict_step(input logic [7:0] ang, input logic [11:0] r1, r2, r3,
                                input logic new_sweep, end_sweep);
        logic [11:0] smp [3];
        int          sum;
        int          cnt;
        int          need;
        int          avg_dist;
        int          delta;
        bit          usable;
        seg_word_t   w;
        smp[0] = r1;
        smp[1] = r2;
        smp[2] = r3;
        step_words.delete();
        if (new_sweep)
            clear_sweep();
        sum = 0;
        cnt = 0;
        avg_dist = 4095;
        for (int i = 0; i < SAMPLES_USED; i++)
        begin
            if (smp[i] >= model_cfg.min_valid_distance && smp[i] <= model_cfg.max_valid_distance)
            begin
                sum += smp[i];
                cnt++;
            end
        end
        need = (model_cfg.min_valid_count == 0) ? 1 : model_cfg.min_valid_count;
        usable = cnt >= need && cnt != 0;
        if (usable)
            avg_dist = sum / cnt;
        if (usable && avg_dist < model_cfg.object_threshold)
        begin
            delta = (avg_dist > last_dist) ? avg_dist - last_dist : last_dist - avg_dist;
            if (!in_run)
            begin
                in_run = 1'b1;
                run_from = ang;
                if (avg_dist < run_min)
                    run_min = avg_dist;
            end
            else if (delta <= model_cfg.change_threshold)
            begin
                if (avg_dist < run_min)
                    run_min = avg_dist;
            end
        end
        else if (in_run)
            close_object(ang, (ang >= model_cfg.angle_step) ? ang - model_cfg.angle_step : 8'd0);
        last_dist = avg_dist;
        if (end_sweep)
        begin
            if (in_run)
                close_object(ang, ang);
            in_run = 1'b0;
            run_min = 4095;
            step_words.push_back('{1'b1, 5'd0, 8'd0, 8'd0, 12'd0, 8'd0, 5'(narrow_id),
                                   1'b0, 1'b0});
        end
        for (int i = 0; i < step_words.size(); i++)
        begin
            w = step_words[i];
            w.overflow = dropped;
            w.last_word = (i == step_words.size() - 1);
            expected_words.push_back(w);
        end
    endtask

    // enters just after a rising edge, returns at the edge that takes the word
    task automatic send_step(input logic [7:0] ang, input logic [11:0] r1, r2, r3,
                             input logic new_sweep, end_sweep);
        @(negedge clk);
        while ($urandom_range(99) < tx_gap_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {4'b0, r3, r2, r1, ang};
        s_axis_tuser <= new_sweep;
        s_axis_tlast <= end_sweep;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        predict_step(ang, r1, r2, r3, new_sweep, end_sweep);
    endtask

    task automatic wait_drained();
        @(negedge clk);
        s_axis_tvalid <= 1'b0;
        while (expected_words.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input reg_idx_t idx, input logic [11:0] val);
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_addr <= idx;
        cfg_wdata <= val;
        @(posedge clk);
        case (idx)
            REG_MIN_VALID_DISTANCE: model_cfg.min_valid_distance = val;
            REG_MAX_VALID_DISTANCE: model_cfg.max_valid_distance = val;
            REG_MIN_VALID_COUNT:    model_cfg.min_valid_count = val[1:0];
            REG_OBJECT_THRESHOLD:   model_cfg.object_threshold = val;
            REG_CHANGE_THRESHOLD:   model_cfg.change_threshold = val;
            REG_MIN_WIDTH:          model_cfg.min_width = val[7:0];
            REG_MAX_WIDTH:          model_cfg.max_width = val[7:0];
            REG_ANGLE_STEP:         model_cfg.angle_step = val[7:0];
            default: ;
        endcase
    endtask

    task automatic write_config(input cfg_t c);
        write_reg(REG_MIN_VALID_DISTANCE, c.min_valid_distance);
        write_reg(REG_MAX_VALID_DISTANCE, c.max_valid_distance);
        write_reg(REG_MIN_VALID_COUNT, {10'd0, c.min_valid_count});
        write_reg(REG_OBJECT_THRESHOLD, c.object_threshold);
        write_reg(REG_CHANGE_THRESHOLD, c.change_threshold);
        write_reg(REG_MIN_WIDTH, {4'd0, c.min_width});
        write_reg(REG_MAX_WIDTH, {4'd0, c.max_width});
        write_reg(REG_ANGLE_STEP, {4'd0, c.angle_step});
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    function automatic cfg_t random_config();
        cfg_t c;
        c.min_valid_distance = 12'($urandom_range(0, 100));
        c.max_valid_distance = 12'($urandom_range(900, 4095));
        c.min_valid_count = 2'($urandom_range(0, 3));
        c.object_threshold = 12'($urandom_range(200, 2500));
        c.change_threshold = 12'($urandom_range(0, 120));
        c.min_width = 8'($urandom_range(0, 16));
        c.max_width = 8'($urandom_range(16, 180));
        c.angle_step = 8'($urandom_range(1, 12));
        return c;
    endfunction

    // a range level that the current settings see as object (or as background)
    function automatic int pick_level(input bit on_obj);
        int lo;
        int hi;
        if (on_obj)
        begin
            lo = model_cfg.min_valid_distance;
            hi = model_cfg.object_threshold;
            hi = hi - 1;
            if (hi > model_cfg.max_valid_distance)
                hi = model_cfg.max_valid_distance;
        end
        else
        begin
            lo = model_cfg.object_threshold;
            hi = model_cfg.max_valid_distance;
        end
        if (lo > hi)
            return $urandom_range(0, 4095);
        return $urandom_range(lo, hi);
    endfunction

    function automatic logic [11:0] jitter(input int lvl);
        int v;
        if ($urandom_range(99) < 8)
            return 12'($urandom_range(0, 4095));
        v = lvl + $urandom_range(0, 4) - 2;
        if (v < 0)
            v = 0;
        if (v > 4095)
            v = 4095;
        return v[11:0];
    endfunction

    task automatic run_sweeps(input int n_items);
        int sent;
        int len;
        int stp;
        int ang;
        int lvl;
        int d;
        bit on_obj;
        sent = 0;
        while (sent < n_items)
        begin
            if ($urandom_range(99) < 15)
            begin
                // broken sweep: arbitrary angles, samples and markers
                len = $urandom_range(3, 12);
                for (int k = 0; k < len; k++)
                    send_step(8'($urandom_range(0, 180)), 12'($urandom_range(0, 4095)),
                              12'($urandom_range(0, 4095)), 12'($urandom_range(0, 4095)),
                              $urandom_range(7) == 0, $urandom_range(7) == 0);
                sent += len;
            end
            else
            begin
                stp = model_cfg.angle_step;
                if (stp == 0)
                    stp = 1;
                ang = $urandom_range(0, 10);
                len = $urandom_range(6, 40);
                if (len > (180 - ang) / stp + 1)
                    len = (180 - ang) / stp + 1;
                on_obj = 1'b0;
                lvl = pick_level(1'b0);
                for (int k = 0; k < len; k++)
                begin
                    if ($urandom_range(99) < 25)
                    begin
                        on_obj = !on_obj;
                        lvl = pick_level(on_obj);
                    end
                    else if (on_obj)
                    begin
                        if ($urandom_range(99) < 10)
                            lvl = pick_level(1'b1);
                        else
                        begin
                            d = (model_cfg.change_threshold > 40) ? 40 : model_cfg.change_threshold;
                            lvl = lvl + $urandom_range(0, 2 * d) - d;
                        end
                    end
                    send_step(8'(ang + k * stp), jitter(lvl), jitter(lvl), jitter(lvl),
                              k == 0 && $urandom_range(99) < 95, k == len - 1);
                end
                sent += len;
            end
        end
    endtask

    task automatic test_directed();
        send_step(0, 0, 0, 0, 1, 1);
        send_step(0, 4095, 4095, 4095, 1, 0);
        send_step(4, 500, 500, 500, 0, 0);
        send_step(8, 510, 19, 1101, 0, 0);
        send_step(12, 20, 20, 21, 0, 0);
        send_step(16, 1100, 1100, 0, 0, 0);
        send_step(20, 300, 300, 300, 0, 0);
        send_step(24, 600, 600, 600, 0, 0);
        send_step(28, 610, 610, 610, 0, 0);
        send_step(32, 999, 999, 999, 0, 0);
        send_step(36, 1000, 1000, 1000, 0, 0);
        send_step(40, 400, 400, 400, 0, 0);
        send_step(2, 4095, 0, 4095, 0, 0);
        send_step(44, 200, 202, 204, 0, 0);
        send_step(48, 205, 205, 205, 0, 0);
        send_step(52, 210, 210, 210, 0, 1);
        send_step(0, 100, 100, 100, 1, 0);
        send_step(4, 100, 100, 100, 1, 0);
        send_step(12, 4095, 4095, 4095, 0, 0);
        send_step(180, 2048, 1024, 3000, 0, 1);
        wait_drained();
    endtask

    task automatic test_register_extremes();
        cfg_t corner [5];
        corner[0] = cfg_t'{12'd0, 12'd4095, 2'd0, 12'd4095, 12'd0, 8'd0, 8'd180, 8'd180};
        corner[1] = cfg_t'{12'd4095, 12'd0, 2'd1, 12'd1000, 12'd20, 8'd4, 8'd60, 8'd4};
        corner[2] = cfg_t'{12'd0, 12'd4095, 2'd1, 12'd0, 12'd4095, 8'd0, 8'd180, 8'd1};
        corner[3] = cfg_t'{12'd0, 12'd4095, 2'd3, 12'd4095, 12'd4095, 8'd180, 8'd180, 8'd1};
        corner[4] = cfg_t'{12'd20, 12'd1100, 2'd2, 12'd4095, 12'd20, 8'd180, 8'd0, 8'd2};
        for (int i = 0; i < 5; i++)
        begin
            write_config(corner[i]);
            if (i == 0)
            begin
                // far step before one angle step has passed: end angle clamps to zero
                send_step(0, 0, 4095, 4095, 1, 0);
                send_step(5, 2730, 2730, 2730, 0, 0);
                send_step(7, 4095, 4095, 4095, 0, 1);
            end
            if (i == 3)
            begin
                send_step(0, 4094, 0, 2, 1, 0);
                send_step(180, 1000, 1001, 1002, 0, 1);
            end
            run_sweeps(18);
            wait_drained();
        end
    endtask

    task automatic test_capacity();
        write_config(cfg_t'{12'd0, 12'd4095, 2'd1, 12'd1000, 12'd4095, 8'd1, 8'd180, 8'd1});
        send_step(0, 4095, 4095, 4095, 1, 0);
        for (int k = 0; k < OBJ_CAPACITY + 4; k++)
        begin
            send_step(8'(2 * k + 1), 100, 100, 100, 0, 0);
            send_step(8'(2 * k + 2), 2000, 2000, 2000, 0, 0);
        end
        send_step(8'(2 * OBJ_CAPACITY + 9), 100, 100, 100, 0, 1);
        wait_drained();
    endtask

    task automatic test_random_phases();
        int tx_set [3];
        int rx_set [3];
        tx_set = '{6, 79, 0};
        rx_set = '{79, 6, 0};
        for (int p = 0; p < 3; p++)
        begin
            tx_gap_pct = tx_set[p];
            rx_stall_pct = rx_set[p];
            write_config(random_config());
            run_sweeps(80);
            wait_drained();
        end
    endtask

    task automatic test_output_backpressure();
        write_config(cfg_t'{12'd0, 12'd4095, 2'd1, 12'd1000, 12'd4095, 8'd1, 8'd180, 8'd2});
        tx_gap_pct = 0;
        rx_stall_pct = 0;
        rx_hold_req = 300;
        run_sweeps(60);
        wait_drained();
        run_sweeps(20);
        wait_drained();
    endtask

    always @(negedge clk)
    begin
        if (rx_hold_req > 0)
        begin
            rx_hold_req--;
            m_axis_tready <= 1'b0;
        end
        else
            m_axis_tready <= ($urandom_range(99) >= rx_stall_pct);
    end

    always @(posedge clk)
    begin
        seg_word_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (expected_words.size() == 0)
                report_error("result word with nothing expected");
            else
            begin
                want = expected_words.pop_front();
                check_field("kind", m_axis_tuser, want.kind);
                check_field("obj_num", m_axis_tdata[4:0], want.obj_num);
                check_field("start_deg", m_axis_tdata[12:5], want.start_deg);
                check_field("end_deg", m_axis_tdata[20:13], want.end_deg);
                check_field("nearest", m_axis_tdata[32:21], want.nearest);
                check_field("width_deg", m_axis_tdata[40:33], want.width_deg);
                check_field("target_number", m_axis_tdata[45:41], want.target_num);
                check_field("overflow", m_axis_tdata[46], want.overflow);
                check_field("last_of_run", m_axis_tlast, want.last_word);
            end
        end
    end

    initial
    begin
        model_cfg = cfg_t'{12'd20, 12'd1100, 2'd2, 12'd1000, 12'd20, 8'd4, 8'd60, 8'd4};
        clear_sweep();
        tx_gap_pct = 6;
        rx_stall_pct = 79;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        test_directed();
        test_register_extremes();
        test_capacity();
        test_random_phases();
        test_output_backpressure();
        if (mismatch_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

    initial
    begin
        #5000000;
        $display("DONE: errors detected");
        $finish;
    end

endmodule
